FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Holds the request, result and stored-entry structs, the command and status
// codes and the sequencer states. Depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int DATA_W              = 32;
  localparam int PRIO_W              = 16;
  localparam int COUNT_OUT_W         = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 8;

  localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;
  localparam logic signed [DATA_W-1:0] ENQ_DATA   = 32'sd0;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] data_in;
    logic signed [PRIO_W-1:0] priority_in;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    status_t                  status;
    logic [COUNT_OUT_W-1:0]   count_out;
  } out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ_READ,
    S_ENQ_CMP,
    S_ENQ_PUT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: entry memory, ring pointers and the
// insertion sequencer with its single priority comparator.
// Depends on spq_pkg.
`default_nettype none

// Usage
// An item is taken at a rising edge where start is high and busy is low. The
// request carries cmd (enqueue or dequeue), a data word and a signed priority.
// Every item yields exactly one result on the result port, flagged by done
// for a single cycle; the receiver cannot hold it off, so it must sample it.
// The entries live in a ring buffer memory ordered from head (highest
// priority) to tail; equal priorities leave in arrival order.
// What each kind of request does:
//   enqueue when full, dequeue when empty, enqueue into an empty queue: done
//   and the result are registered straight from idle; busy never rises, so a
//   new item may be taken while done shows.
//   dequeue: one memory read of the head entry in S_DEQ_READ, busy high.
//   enqueue: busy stays high while the walk shifts the m stored entries with
//   a lower priority than the new one, and then the new entry is written.
// The insertion walk makes one memory read, one priority compare and one
// shifted entry per cycle from the tail toward the head. Every result also
// reports the entry count after the operation.
// Reset clears the count, the ring pointers and the sequencer; the memory
// holds no reset value and needs no clearing pass.

module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire spq_pkg::in_t  request,
  output logic               busy,
  output logic               done,
  output spq_pkg::out_t      result
);

  import spq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] left, left_next;
  entry_t           pend, pend_next;
  logic             done_next;
  out_t             result_next;

  entry_t           mem [QUEUE_DEPTH];
  entry_t           rd_q;
  logic [PTR_W-1:0] raddr;
  logic             we;
  logic [PTR_W-1:0] waddr;
  entry_t           wdata;
  entry_t           new_entry;
  logic             shift_down;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign new_entry  = '{data: request.data_in, prio: request.priority_in};
  // The single comparator: does the stored entry rank below the new one?
  assign shift_down = ($signed(rd_q.prio) < $signed(pend.prio));

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    wr_ptr_next = wr_ptr;
    left_next   = left;
    pend_next   = pend;
    done_next   = 1'b0;
    result_next = result;
    we          = 1'b0;
    waddr       = wr_ptr;
    wdata       = pend;
    raddr       = ptr_dec(wr_ptr);

    case (state)
      S_IDLE: begin
        if (start) begin
          if (request.cmd == CMD_DEQ) begin
            if (count == '0) begin
              done_next   = 1'b1;
              result_next = '{data_out: EMPTY_DATA, status: ST_EMPTY,
                              count_out: COUNT_OUT_W'(count)};
            end else begin
              raddr      = head;
              state_next = S_DEQ_READ;
            end
          end else begin
            if (count == FULL_CNT) begin
              done_next   = 1'b1;
              result_next = '{data_out: ENQ_DATA, status: ST_FULL,
                              count_out: COUNT_OUT_W'(count)};
            end else if (count == '0) begin
              we          = 1'b1;
              waddr       = tail;
              wdata       = new_entry;
              tail_next   = ptr_inc(tail);
              count_next  = count + 1'b1;
              done_next   = 1'b1;
              result_next = '{data_out: ENQ_DATA, status: ST_OK,
                              count_out: COUNT_OUT_W'(count_next)};
            end else begin
              pend_next   = new_entry;
              wr_ptr_next = tail;
              left_next   = PTR_W'(count);
              raddr       = ptr_dec(tail);
              state_next  = S_ENQ_CMP;
            end
          end
        end
      end

      S_DEQ_READ: begin
        head_next   = ptr_inc(head);
        count_next  = count - 1'b1;
        done_next   = 1'b1;
        result_next = '{data_out: rd_q.data, status: ST_OK,
                        count_out: COUNT_OUT_W'(count_next)};
        state_next  = S_IDLE;
      end

      S_ENQ_CMP: begin
        if (shift_down) begin
          // Move the lower-ranked entry one slot toward the tail.
          we          = 1'b1;
          waddr       = wr_ptr;
          wdata       = rd_q;
          wr_ptr_next = ptr_dec(wr_ptr);
          left_next   = left - 1'b1;
          raddr       = ptr_dec(ptr_dec(wr_ptr));
          if (left == PTR_W'(1)) begin
            state_next = S_ENQ_PUT;
          end
        end else begin
          we          = 1'b1;
          tail_next   = ptr_inc(tail);
          count_next  = count + 1'b1;
          done_next   = 1'b1;
          result_next = '{data_out: ENQ_DATA, status: ST_OK,
                          count_out: COUNT_OUT_W'(count_next)};
          state_next  = S_IDLE;
        end
      end

      S_ENQ_PUT: begin
        we          = 1'b1;
        tail_next   = ptr_inc(tail);
        count_next  = count + 1'b1;
        done_next   = 1'b1;
        result_next = '{data_out: ENQ_DATA, status: ST_OK,
                        count_out: COUNT_OUT_W'(count_next)};
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_ptr <= wr_ptr_next;
    left   <= left_next;
    pend   <= pend_next;
    result <= result_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count exceeds the queue depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> count == FULL_CNT)
    else $error("full status reported while space remains");

  a_walk_has_entries: assert property (@(posedge clk) disable iff (rst)
    state == S_ENQ_CMP |-> left != '0)
    else $error("insertion walk ran past the head");

  a_deq_reads: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.cmd == CMD_DEQ && count != '0
    |=> state == S_DEQ_READ)
    else $error("dequeue on a non-empty queue did not read the head");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DEQ_READ |=> done && state == S_IDLE)
    else $error("dequeue read did not deliver its item");

endmodule

`default_nettype wire
